// ===== rtl/core/tcpp_pkg.sv =====
package tcpp_pkg;

    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;

    localparam logic [1:0] K_CONT = 2'd0;
    localparam logic [1:0] K_DATA = 2'd1;
    localparam logic [1:0] K_CMD  = 2'd2;
    localparam logic [1:0] K_ERR  = 2'd3;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_WILL   = 3'd1;
    localparam logic [2:0] OP_WONT   = 3'd2;
    localparam logic [2:0] OP_DO     = 3'd3;
    localparam logic [2:0] OP_DONT   = 3'd4;
    localparam logic [2:0] OP_FINISH = 3'd5;

    typedef struct packed {
        logic [1:0]      kind;
        logic [7:0]      data;
        logic [2:0]      opc;
        logic [7:0]      opt;
        logic [5:0]      clr;
        logic            n_ge2;
        logic            n_ge3;
        logic            n_ge6;
        logic [5:0][7:0] head;
    } op_t;

endpackage

// ===== rtl/core/tcpp_if.sv =====
interface tcpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic [5:0] flags_clear;

    modport source (output valid, output rx_byte, output flags_clear, input ready);
    modport sink (input valid, input rx_byte, input flags_clear, output ready);
endinterface

interface tcpp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic [31:0] baud_rate;
    logic [3:0]  data_bits;
    logic [2:0]  parity_mode;
    logic [1:0]  stop_mode;
    logic [1:0]  flow_mode;
    logic [2:0]  control_lines;
    logic [6:0]  status_flags;
    logic [15:0] option_reply;
    logic [15:0] state_masks;
    logic [23:0] last_subneg;

    modport source (output valid, output result_kind, output data_byte, output baud_rate,
        output data_bits, output parity_mode, output stop_mode, output flow_mode,
        output control_lines, output status_flags, output option_reply,
        output state_masks, output last_subneg, input ready);
    modport sink (input valid, input result_kind, input data_byte, input baud_rate,
        input data_bits, input parity_mode, input stop_mode, input flow_mode,
        input control_lines, input status_flags, input option_reply,
        input state_masks, input last_subneg, output ready);
endinterface

// ===== rtl/core/tcpp_front.sv =====
module tcpp_front #(
    parameter int SUBNEG_BUFFER_BYTES = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    tcpp_in_if.sink        stream,
    input  logic           full,
    output logic           push,
    output tcpp_pkg::op_t  op
);

    localparam int CW = $clog2(SUBNEG_BUFFER_BYTES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(SUBNEG_BUFFER_BYTES);

    localparam logic [3:0] PH_DATA   = 4'd0;
    localparam logic [3:0] PH_IAC    = 4'd1;
    localparam logic [3:0] PH_WILL   = 4'd2;
    localparam logic [3:0] PH_WONT   = 4'd3;
    localparam logic [3:0] PH_DO     = 4'd4;
    localparam logic [3:0] PH_DONT   = 4'd5;
    localparam logic [3:0] PH_SB     = 4'd6;
    localparam logic [3:0] PH_SBDATA = 4'd7;
    localparam logic [3:0] PH_SBIAC  = 4'd8;

    logic [3:0]      phase_reg;
    logic [3:0]      phase_next;
    logic [CW-1:0]   count_reg;
    logic [5:0][7:0] head_reg;
    logic            store;
    logic [7:0]      store_val;
    logic            count_clr;
    logic [7:0]      b;

    assign b = stream.rx_byte;
    assign stream.ready = !full;
    assign push = stream.valid && !full;

    always_comb
    begin
        phase_next = phase_reg;
        op.kind = tcpp_pkg::K_CONT;
        op.data = 8'd0;
        op.opc = tcpp_pkg::OP_NONE;
        op.opt = b;
        op.clr = stream.flags_clear;
        op.n_ge2 = count_reg >= CW'(2);
        op.n_ge3 = count_reg >= CW'(3);
        op.n_ge6 = count_reg >= CW'(6);
        op.head = head_reg;
        store = 1'b0;
        store_val = b;
        count_clr = 1'b0;
        case (phase_reg)
            PH_DATA:
            begin
                if (b == tcpp_pkg::B_IAC)
                begin
                    phase_next = PH_IAC;
                end
                else
                begin
                    op.kind = tcpp_pkg::K_DATA;
                    op.data = b;
                end
            end
            PH_IAC:
            begin
                phase_next = PH_DATA;
                if (b == tcpp_pkg::B_IAC)
                begin
                    op.kind = tcpp_pkg::K_DATA;
                    op.data = tcpp_pkg::B_IAC;
                end
                else if (b == tcpp_pkg::B_WILL)
                    phase_next = PH_WILL;
                else if (b == tcpp_pkg::B_WONT)
                    phase_next = PH_WONT;
                else if (b == tcpp_pkg::B_DO)
                    phase_next = PH_DO;
                else if (b == tcpp_pkg::B_DONT)
                    phase_next = PH_DONT;
                else if (b == tcpp_pkg::B_SB)
                begin
                    phase_next = PH_SB;
                    count_clr = 1'b1;
                end
            end
            PH_WILL:
            begin
                op.opc = tcpp_pkg::OP_WILL;
                op.kind = tcpp_pkg::K_CMD;
                phase_next = PH_DATA;
            end
            PH_WONT:
            begin
                op.opc = tcpp_pkg::OP_WONT;
                op.kind = tcpp_pkg::K_CMD;
                phase_next = PH_DATA;
            end
            PH_DO:
            begin
                op.opc = tcpp_pkg::OP_DO;
                op.kind = tcpp_pkg::K_CMD;
                phase_next = PH_DATA;
            end
            PH_DONT:
            begin
                op.opc = tcpp_pkg::OP_DONT;
                op.kind = tcpp_pkg::K_CMD;
                phase_next = PH_DATA;
            end
            PH_SB:
            begin
                store = 1'b1;
                phase_next = PH_SBDATA;
            end
            PH_SBDATA:
            begin
                if (b == tcpp_pkg::B_IAC)
                    phase_next = PH_SBIAC;
                else
                    store = 1'b1;
            end
            PH_SBIAC:
            begin
                if (b == tcpp_pkg::B_SE)
                begin
                    op.opc = tcpp_pkg::OP_FINISH;
                    op.kind = tcpp_pkg::K_CMD;
                    phase_next = PH_DATA;
                end
                else if (b == tcpp_pkg::B_IAC)
                begin
                    store = 1'b1;
                    store_val = tcpp_pkg::B_IAC;
                    phase_next = PH_SBDATA;
                end
                else
                begin
                    op.kind = tcpp_pkg::K_ERR;
                    phase_next = PH_DATA;
                end
            end
            default:
            begin
                op.kind = tcpp_pkg::K_ERR;
                phase_next = PH_DATA;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DATA;
            count_reg <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            if (count_clr)
                count_reg <= '0;
            else if (store && count_reg < CNT_MAX)
                count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && store && count_reg < CW'(6))
            head_reg[count_reg[2:0]] <= store_val;
    end

endmodule

// ===== rtl/core/tcpp_queue.sv =====
module tcpp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tcpp_pkg::op_t  push_op,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output tcpp_pkg::op_t  head_op
);

    tcpp_pkg::op_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head_op = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ===== rtl/core/tcpp_back.sv =====
module tcpp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  tcpp_pkg::op_t  q,
    output logic           pop,
    tcpp_out_if.source     result
);

    localparam logic [7:0] OPT_BIN = 8'd0;
    localparam logic [7:0] OPT_SGA = 8'd3;
    localparam logic [7:0] OPT_COM = 8'd44;

    localparam logic [7:0] CMD_SIGNATURE = 8'd0;
    localparam logic [7:0] CMD_BAUD      = 8'd1;
    localparam logic [7:0] CMD_DATASIZE  = 8'd2;
    localparam logic [7:0] CMD_PARITY    = 8'd3;
    localparam logic [7:0] CMD_STOPSIZE  = 8'd4;
    localparam logic [7:0] CMD_CONTROL   = 8'd5;
    localparam logic [7:0] CMD_LINEMASK  = 8'd10;
    localparam logic [7:0] CMD_MODEMMASK = 8'd11;
    localparam logic [7:0] CMD_PURGE     = 8'd12;

    localparam logic [7:0] CTL_BREAK_ON  = 8'd5;
    localparam logic [7:0] CTL_BREAK_OFF = 8'd6;
    localparam logic [7:0] CTL_DTR_ON    = 8'd8;
    localparam logic [7:0] CTL_DTR_OFF   = 8'd9;
    localparam logic [7:0] CTL_RTS_ON    = 8'd11;
    localparam logic [7:0] CTL_RTS_OFF   = 8'd12;

    localparam logic [5:0] F_SET   = 6'h01;
    localparam logic [5:0] F_LINE  = 6'h02;
    localparam logic [5:0] F_MODEM = 6'h04;
    localparam logic [5:0] F_BREAK = 6'h08;
    localparam logic [5:0] F_SIG   = 6'h10;
    localparam logic [5:0] F_REPLY = 6'h20;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  data_reg;
    logic [31:0] baud_reg, baud_next;
    logic [1:0]  dsz_reg, dsz_next;
    logic [2:0]  parity_reg, parity_next;
    logic [1:0]  stop_reg, stop_next;
    logic [1:0]  flow_reg, flow_next;
    logic [2:0]  lines_reg, lines_next;
    logic [15:0] mask_reg, mask_next;
    logic [5:0]  ev_reg, ev_next;
    logic [2:0]  peer_reg, peer_next;
    logic [15:0] reply_reg, reply_next;
    logic [23:0] last_reg, last_next;
    logic [7:0]  cmd;
    logic [7:0]  v;
    logic [7:0]  v_minus5;
    logic [31:0] baud_in;
    logic        opt_ok;

    assign pop = !empty && (!out_valid_reg || result.ready);

    assign cmd = q.head[1];
    assign v = q.head[2];
    assign v_minus5 = v - 8'd5;
    assign baud_in = {q.head[2], q.head[3], q.head[4], q.head[5]};
    assign opt_ok = q.opt == OPT_BIN || q.opt == OPT_SGA;

    always_comb
    begin
        baud_next = baud_reg;
        dsz_next = dsz_reg;
        parity_next = parity_reg;
        stop_next = stop_reg;
        flow_next = flow_reg;
        lines_next = lines_reg;
        mask_next = mask_reg;
        ev_next = ev_reg & ~q.clr;
        peer_next = peer_reg;
        reply_next = reply_reg;
        last_next = last_reg;
        case (q.opc)
            tcpp_pkg::OP_WILL:
            begin
                if (q.opt == OPT_COM)
                    peer_next = {peer_reg[1], peer_reg[1], 1'b1};
                else
                begin
                    reply_next = {opt_ok ? tcpp_pkg::B_DO : tcpp_pkg::B_DONT, q.opt};
                    ev_next = ev_next | F_REPLY;
                end
            end
            tcpp_pkg::OP_WONT:
            begin
                if (q.opt == OPT_COM)
                    peer_next[0] = 1'b0;
            end
            tcpp_pkg::OP_DO:
            begin
                if (q.opt == OPT_COM)
                    peer_next = {peer_reg[0], 1'b1, peer_reg[0]};
                else
                begin
                    reply_next = {opt_ok ? tcpp_pkg::B_WILL : tcpp_pkg::B_WONT, q.opt};
                    ev_next = ev_next | F_REPLY;
                end
            end
            tcpp_pkg::OP_DONT:
            begin
                if (q.opt == OPT_COM)
                    peer_next[1] = 1'b0;
            end
            tcpp_pkg::OP_FINISH:
            begin
                if (q.n_ge2 && q.head[0] == OPT_COM)
                begin
                    last_next[23:16] = cmd;
                    case (cmd)
                        CMD_SIGNATURE:
                            ev_next = ev_next | F_SIG;
                        CMD_BAUD:
                        begin
                            if (q.n_ge6 && baud_in != 32'd0)
                            begin
                                baud_next = baud_in;
                                ev_next = ev_next | F_SET | F_LINE;
                            end
                        end
                        CMD_DATASIZE:
                        begin
                            if (q.n_ge3 && v >= 8'd5 && v <= 8'd8)
                            begin
                                dsz_next = v_minus5[1:0];
                                ev_next = ev_next | F_SET | F_LINE;
                            end
                        end
                        CMD_PARITY:
                        begin
                            if (q.n_ge3 && v >= 8'd1 && v <= 8'd5)
                            begin
                                parity_next = v[2:0];
                                ev_next = ev_next | F_SET | F_LINE;
                            end
                        end
                        CMD_STOPSIZE:
                        begin
                            if (q.n_ge3 && v >= 8'd1 && v <= 8'd3)
                            begin
                                stop_next = v[1:0];
                                ev_next = ev_next | F_SET | F_LINE;
                            end
                        end
                        CMD_CONTROL:
                        begin
                            if (q.n_ge3)
                            begin
                                last_next[15:8] = v;
                                if (v >= 8'd1 && v <= 8'd3)
                                begin
                                    flow_next = v[1:0];
                                    ev_next = ev_next | F_SET;
                                end
                                else if (v == CTL_BREAK_ON || v == CTL_BREAK_OFF)
                                begin
                                    lines_next[2] = v == CTL_BREAK_ON;
                                    ev_next = ev_next | F_SET | F_BREAK;
                                end
                                else if (v == CTL_DTR_ON || v == CTL_DTR_OFF)
                                begin
                                    lines_next[0] = v == CTL_DTR_ON;
                                    ev_next = ev_next | F_SET | F_MODEM;
                                end
                                else if (v == CTL_RTS_ON || v == CTL_RTS_OFF)
                                begin
                                    lines_next[1] = v == CTL_RTS_ON;
                                    ev_next = ev_next | F_SET | F_MODEM;
                                end
                            end
                        end
                        CMD_LINEMASK:
                        begin
                            if (q.n_ge3)
                                mask_next[15:8] = v;
                        end
                        CMD_MODEMMASK:
                        begin
                            if (q.n_ge3)
                                mask_next[7:0] = v;
                        end
                        CMD_PURGE:
                        begin
                            if (q.n_ge3)
                                last_next[7:0] = v;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            baud_reg <= 32'd115200;
            dsz_reg <= 2'd3;
            parity_reg <= 3'd1;
            stop_reg <= 2'd1;
            flow_reg <= 2'd1;
            lines_reg <= 3'd0;
            mask_reg <= 16'hFFFF;
            ev_reg <= 6'd0;
            peer_reg <= 3'd0;
            reply_reg <= 16'd0;
            last_reg <= 24'hFF0000;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
            baud_reg <= baud_next;
            dsz_reg <= dsz_next;
            parity_reg <= parity_next;
            stop_reg <= stop_next;
            flow_reg <= flow_next;
            lines_reg <= lines_next;
            mask_reg <= mask_next;
            ev_reg <= ev_next;
            peer_reg <= peer_next;
            reply_reg <= reply_next;
            last_reg <= last_next;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= q.kind;
            data_reg <= q.data;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.result_kind = kind_reg;
    assign result.data_byte = data_reg;
    assign result.baud_rate = baud_reg;
    assign result.data_bits = {2'b00, dsz_reg} + 4'd5;
    assign result.parity_mode = parity_reg;
    assign result.stop_mode = stop_reg;
    assign result.flow_mode = flow_reg;
    assign result.control_lines = lines_reg;
    assign result.status_flags = {peer_reg[2], ev_reg};
    assign result.option_reply = reply_reg;
    assign result.state_masks = mask_reg;
    assign result.last_subneg = last_reg;

endmodule

// ===== rtl/core/telnet_com_port_control_parser_core.sv =====
// telnet com port control parser: receive side of an rfc 2217 link
// stream: one received telnet byte per item, with a mask of event flags
//   to clear before that byte is handled
// result: one item per input item, in order; kind (continue, data byte,
//   command done, protocol error), the unescaped byte, and a snapshot of
//   all serial settings, masks, pending option reply and event flags
// the front end tracks the telnet phase and the first six subnegotiation
//   bytes and classifies each byte; a two-entry queue feeds the back end,
//   which applies negotiations and com port commands to the settings
// an accepted item is written into the queue, then popped into the result registers
// throughput: one item per cycle while result.ready is high, set by the combinational phase decode
// reset: data phase, 115200 baud 8n1, no flow control, lines low,
//   masks 0xffff, flags and reply clear
// when the receiver stalls the result holds, the queue fills, and
//   stream.ready drops once two items are waiting
module telnet_com_port_control_parser_core #(
    parameter int SUBNEG_BUFFER_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    tcpp_in_if.sink     stream,
    tcpp_out_if.source  result
);

    tcpp_pkg::op_t push_op;
    tcpp_pkg::op_t head_op;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    tcpp_front #(
        .SUBNEG_BUFFER_BYTES(SUBNEG_BUFFER_BYTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .full   (full),
        .push   (push),
        .op     (push_op)
    );

    tcpp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (full),
        .pop     (pop),
        .empty   (empty),
        .head_op (head_op)
    );

    tcpp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .q      (head_op),
        .pop    (pop),
        .result (result)
    );

endmodule
